FILE: design/tvi_pkg.sv
// ----------------------------------------------------------------------------
// Trilinear voxel interpolator package
// Widths, register indexes and shared types for the interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package tvi_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int FRAC_BITS      = 8;
    localparam int COORD_INT_BITS = 10;
    localparam int COORD_W        = COORD_INT_BITS + FRAC_BITS + 1;
    localparam int SIZE_W         = 11;
    localparam int CFG_IDX_W      = 2;

    localparam int WGT_W = FRAC_BITS + 1;
    localparam int Y_W   = SAMPLE_BITS + FRAC_BITS;
    localparam int Z_W   = SAMPLE_BITS + 2 * FRAC_BITS;
    localparam int X_W   = SAMPLE_BITS + 3 * FRAC_BITS;

    localparam logic [CFG_IDX_W-1:0] REG_X_SIZE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_Y_SIZE = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_Z_SIZE = CFG_IDX_W'(2);

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);

    typedef logic [SAMPLE_BITS-1:0]    t_sample;
    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        logic [SIZE_W-1:0] x_size;
        logic [SIZE_W-1:0] y_size;
        logic [SIZE_W-1:0] z_size;
    } t_vol_size;

endpackage

`default_nettype wire

FILE: design/tvi_ifs.sv
// ----------------------------------------------------------------------------
// Trilinear voxel interpolator channels
// Sample point, result and configuration write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface tvi_in_if;
    logic             valid;
    logic             ready;
    tvi_pkg::t_coord  pos_x;
    tvi_pkg::t_coord  pos_y;
    tvi_pkg::t_coord  pos_z;
    tvi_pkg::t_sample corner_lo_lo_lo;
    tvi_pkg::t_sample corner_hi_lo_lo;
    tvi_pkg::t_sample corner_lo_hi_lo;
    tvi_pkg::t_sample corner_hi_hi_lo;
    tvi_pkg::t_sample corner_lo_lo_hi;
    tvi_pkg::t_sample corner_hi_lo_hi;
    tvi_pkg::t_sample corner_lo_hi_hi;
    tvi_pkg::t_sample corner_hi_hi_hi;

    modport source (
        output valid, pos_x, pos_y, pos_z,
               corner_lo_lo_lo, corner_hi_lo_lo, corner_lo_hi_lo, corner_hi_hi_lo,
               corner_lo_lo_hi, corner_hi_lo_hi, corner_lo_hi_hi, corner_hi_hi_hi,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_y, pos_z,
               corner_lo_lo_lo, corner_hi_lo_lo, corner_lo_hi_lo, corner_hi_hi_lo,
               corner_lo_lo_hi, corner_hi_lo_hi, corner_lo_hi_hi, corner_hi_hi_hi,
        output ready
    );
endinterface

interface tvi_out_if;
    logic             valid;
    logic             ready;
    tvi_pkg::t_sample interp_value;
    logic             inside_res;

    modport source (output valid, interp_value, inside_res, input ready);
    modport sink   (input valid, interp_value, inside_res, output ready);
endinterface

interface tvi_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [tvi_pkg::CFG_IDX_W-1:0]   index;
    logic [tvi_pkg::SIZE_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: design/tvi_range_check.sv
// ----------------------------------------------------------------------------
// Trilinear voxel interpolator range check
// Rounds each coordinate to the nearest voxel and checks it against the volume.
// ----------------------------------------------------------------------------
`default_nettype none

module tvi_range_check (
    input  wire tvi_pkg::t_coord   i_pos_x,
    input  wire tvi_pkg::t_coord   i_pos_y,
    input  wire tvi_pkg::t_coord   i_pos_z,
    input  wire tvi_pkg::t_vol_size i_size,
    output logic                   o_inside
);
    import tvi_pkg::*;

    localparam int HALF_FX = 2 ** (FRAC_BITS - 1);
    localparam logic signed [COORD_W-1:0] NEG_LIMIT = COORD_W'(1 - HALF_FX);

    function automatic logic axis_in(input t_coord pos, input logic [SIZE_W-1:0] size);
        logic [COORD_W-1:0]          sum;
        logic [COORD_W-FRAC_BITS-1:0] rnd;
        sum = $unsigned(pos) + COORD_W'(HALF_FX);
        rnd = sum[COORD_W-1:FRAC_BITS];
        if (pos[COORD_W-1]) begin
            return (pos >= NEG_LIMIT) && (size != '0);
        end
        return {1'b0, rnd} < {1'b0, size};
    endfunction

    assign o_inside = axis_in(i_pos_x, i_size.x_size) &&
                      axis_in(i_pos_y, i_size.y_size) &&
                      axis_in(i_pos_z, i_size.z_size);

endmodule

`default_nettype wire

FILE: design/trilinear_voxel_interpolator.sv
// ----------------------------------------------------------------------------
// Trilinear voxel interpolator
// Three-stage pipeline: y blend, z blend, x blend with final truncation.
// An accepted beat passes the stage one, two and three registers to its result.
// Throughput is one beat per cycle without stalls; a stall holds full stages.
// Reset clears all stage valid bits and sets each volume size to 256.
// ----------------------------------------------------------------------------
`default_nettype none

module trilinear_voxel_interpolator (
    input  wire  i_clk,
    input  wire  i_rst_n,
    tvi_in_if.sink    i_pt,
    tvi_out_if.source o_res,
    tvi_cfg_if.sink   i_cfg
);
    import tvi_pkg::*;

    localparam int ONE_FX = 2 ** FRAC_BITS;

    t_vol_size r_size;
    logic      w_inside;

    logic r1_v, r2_v, r3_v;
    logic w_rdy1, w_rdy2, w_rdy3;

    logic                 r1_inside, r2_inside;
    logic [FRAC_BITS-1:0] r1_fz, r1_fx, r2_fx;
    logic [Y_W-1:0]       r1_y_xlo_zlo, r1_y_xhi_zlo, r1_y_xlo_zhi, r1_y_xhi_zhi;
    logic [Y_W-1:0]       n1_y_xlo_zlo, n1_y_xhi_zlo, n1_y_xlo_zhi, n1_y_xhi_zhi;
    logic [Z_W-1:0]       r2_z_xlo, r2_z_xhi, n2_z_xlo, n2_z_xhi;
    logic [X_W-1:0]       w_full;
    t_sample              r3_val, n3_val;
    logic                 r3_inside;

    logic [WGT_W-1:0] w_wy_hi, w_wy_lo, w_wz_hi, w_wz_lo, w_wx_hi, w_wx_lo;

    // Configuration registers.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size.x_size <= SIZE_RESET;
            r_size.y_size <= SIZE_RESET;
            r_size.z_size <= SIZE_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_X_SIZE: r_size.x_size <= i_cfg.data;
                REG_Y_SIZE: r_size.y_size <= i_cfg.data;
                REG_Z_SIZE: r_size.z_size <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    tvi_range_check u_range (
        .i_pos_x  (i_pt.pos_x),
        .i_pos_y  (i_pt.pos_y),
        .i_pos_z  (i_pt.pos_z),
        .i_size   (r_size),
        .o_inside (w_inside)
    );

    // Per-stage flow control.
    assign w_rdy3     = !r3_v || o_res.ready;
    assign w_rdy2     = !r2_v || w_rdy3;
    assign w_rdy1     = !r1_v || w_rdy2;
    assign i_pt.ready = w_rdy1;

    // Stage one: blend along y.
    assign w_wy_hi = {1'b0, i_pt.pos_y[FRAC_BITS-1:0]};
    assign w_wy_lo = WGT_W'(ONE_FX) - w_wy_hi;

    assign n1_y_xlo_zlo = Y_W'(i_pt.corner_lo_lo_lo) * Y_W'(w_wy_lo) +
                          Y_W'(i_pt.corner_lo_hi_lo) * Y_W'(w_wy_hi);
    assign n1_y_xhi_zlo = Y_W'(i_pt.corner_hi_lo_lo) * Y_W'(w_wy_lo) +
                          Y_W'(i_pt.corner_hi_hi_lo) * Y_W'(w_wy_hi);
    assign n1_y_xlo_zhi = Y_W'(i_pt.corner_lo_lo_hi) * Y_W'(w_wy_lo) +
                          Y_W'(i_pt.corner_lo_hi_hi) * Y_W'(w_wy_hi);
    assign n1_y_xhi_zhi = Y_W'(i_pt.corner_hi_lo_hi) * Y_W'(w_wy_lo) +
                          Y_W'(i_pt.corner_hi_hi_hi) * Y_W'(w_wy_hi);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_rdy1) begin
            r1_v <= i_pt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r1_inside    <= w_inside;
            r1_fz        <= i_pt.pos_z[FRAC_BITS-1:0];
            r1_fx        <= i_pt.pos_x[FRAC_BITS-1:0];
            r1_y_xlo_zlo <= n1_y_xlo_zlo;
            r1_y_xhi_zlo <= n1_y_xhi_zlo;
            r1_y_xlo_zhi <= n1_y_xlo_zhi;
            r1_y_xhi_zhi <= n1_y_xhi_zhi;
        end
    end

    // Stage two: blend along z.
    assign w_wz_hi = {1'b0, r1_fz};
    assign w_wz_lo = WGT_W'(ONE_FX) - w_wz_hi;

    assign n2_z_xlo = Z_W'(r1_y_xlo_zlo) * Z_W'(w_wz_lo) + Z_W'(r1_y_xlo_zhi) * Z_W'(w_wz_hi);
    assign n2_z_xhi = Z_W'(r1_y_xhi_zlo) * Z_W'(w_wz_lo) + Z_W'(r1_y_xhi_zhi) * Z_W'(w_wz_hi);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_rdy2) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r2_inside <= r1_inside;
            r2_fx     <= r1_fx;
            r2_z_xlo  <= n2_z_xlo;
            r2_z_xhi  <= n2_z_xhi;
        end
    end

    // Stage three: blend along x and truncate.
    assign w_wx_hi = {1'b0, r2_fx};
    assign w_wx_lo = WGT_W'(ONE_FX) - w_wx_hi;

    assign w_full = X_W'(r2_z_xlo) * X_W'(w_wx_lo) + X_W'(r2_z_xhi) * X_W'(w_wx_hi);
    assign n3_val = r2_inside ? w_full[X_W-1:3*FRAC_BITS] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (w_rdy3) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r3_inside <= r2_inside;
            r3_val    <= n3_val;
        end
    end

    assign o_res.valid        = r3_v;
    assign o_res.interp_value = r3_val;
    assign o_res.inside_res   = r3_inside;

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// Trilinear voxel interpolator testbench
// Drives sample points through the interpolator under random gaps on the
// point channel and random stalls on the result channel. A directed table
// covers corners, rounding at the volume edges and negative coordinates.
// Random phases follow, one per volume size setting. Every result beat is
// checked in order against a scoreboard fed by the table or a predictor.
// ----------------------------------------------------------------------------
module tb_top;

    import tvi_pkg::*;

    localparam int                   CYCLE_LIMIT  = 250000;
    localparam int                   PHASE_ITEMS  = 67;
    localparam int                   NUM_PHASES   = 9;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED   = CFG_IDX_W'(3);
    localparam longint               COORD_MAX    = 262143;
    localparam longint               COORD_MIN    = -262144;
    localparam longint               HALF_VOXEL   = 128;
    localparam longint unsigned      ONE_VOXEL    = 256;

    typedef struct packed {
        t_coord            x;
        t_coord            y;
        t_coord            z;
        t_sample [7:0]     corner;
    } t_point;

    typedef struct packed {
        t_sample value;
        logic    hit;
    } t_result;

    typedef struct {
        t_point  pt;
        bit      known;
        t_result res;
    } t_row;

    logic clk = 1'b0;
    logic rst_n;

    tvi_in_if  pt_if ();
    tvi_out_if res_if ();
    tvi_cfg_if cfg_if ();

    trilinear_voxel_interpolator dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_pt    (pt_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    t_vol_size   vol_cfg;
    t_result     interp_q[$];
    t_row        rows[$];
    int          mismatch_count = 0;
    int          cycles = 0;
    int unsigned burst_left = 0;
    int unsigned stall_left = 0;
    int unsigned calm_left = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(8, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    function automatic bit axis_hit(longint pos, logic [SIZE_W-1:0] size);
        if (pos < 0) begin
            return (-pos < HALF_VOXEL) && (size != 0);
        end
        return ((pos + HALF_VOXEL) >>> FRAC_BITS) < longint'(size);
    endfunction

    function automatic longint unsigned mix(longint unsigned lo, longint unsigned hi,
                                            longint unsigned f);
        return lo * (ONE_VOXEL - f) + hi * f;
    endfunction

    function automatic t_result interpolate_point(t_point p);
        longint          px, py, pz;
        longint unsigned fx, fy, fz;
        longint unsigned c[8];
        longint unsigned y_ll, y_hl, y_lh, y_hh, z_lo, z_hi, acc;
        t_result         r;
        px = p.x;
        py = p.y;
        pz = p.z;
        r = '0;
        if (!axis_hit(px, vol_cfg.x_size) || !axis_hit(py, vol_cfg.y_size) ||
            !axis_hit(pz, vol_cfg.z_size)) begin
            return r;
        end
        for (int i = 0; i < 8; i++) begin
            c[i] = p.corner[i];
        end
        fx = px & (ONE_VOXEL - 1);
        fy = py & (ONE_VOXEL - 1);
        fz = pz & (ONE_VOXEL - 1);
        y_ll = mix(c[0], c[2], fy);
        y_hl = mix(c[1], c[3], fy);
        y_lh = mix(c[4], c[6], fy);
        y_hh = mix(c[5], c[7], fy);
        z_lo = mix(y_ll, y_lh, fz);
        z_hi = mix(y_hl, y_hh, fz);
        acc = mix(z_lo, z_hi, fx) >> (3 * FRAC_BITS);
        r.value = acc[SAMPLE_BITS-1:0];
        r.hit = 1'b1;
        return r;
    endfunction

    function automatic t_coord rand_coord(logic [SIZE_W-1:0] size);
        longint span, v;
        span = longint'(size) * ONE_VOXEL;
        case ($urandom_range(0, 9))
            0, 1: begin
                return t_coord'($urandom);
            end
            2: v = span - 192 + $urandom_range(0, 127);
            3: v = -longint'($urandom_range(0, 200));
            4: v = longint'($urandom_range(0, int'(size))) * ONE_VOXEL;
            default: v = $urandom_range(0, int'(span) + 127);
        endcase
        if (v > COORD_MAX) begin
            v = COORD_MAX;
        end
        if (v < COORD_MIN) begin
            v = COORD_MIN;
        end
        return t_coord'(v);
    endfunction

    function automatic t_sample rand_corner();
        case ($urandom_range(0, 7))
            0: return '1;
            1: return '0;
            default: return t_sample'($urandom);
        endcase
    endfunction

    function automatic t_point point_at(longint x, longint y, longint z, t_sample base);
        t_point p;
        p.x = t_coord'(x);
        p.y = t_coord'(y);
        p.z = t_coord'(z);
        for (int i = 0; i < 8; i++) begin
            p.corner[i] = base;
        end
        return p;
    endfunction

    function automatic t_point rand_point();
        t_point p;
        p.x = rand_coord(vol_cfg.x_size);
        p.y = rand_coord(vol_cfg.y_size);
        p.z = rand_coord(vol_cfg.z_size);
        for (int i = 0; i < 8; i++) begin
            p.corner[i] = rand_corner();
        end
        return p;
    endfunction

    task automatic add_row(t_point p, bit known, t_sample value, logic hit);
        t_row r;
        r.pt = p;
        r.known = known;
        r.res.value = value;
        r.res.hit = hit;
        rows.push_back(r);
    endtask

    // The point valid stays high from one beat to the next when there is no gap.
    task automatic send_point(t_point p, bit known, t_result typed);
        int gap;
        int pick;
        if (burst_left > 0) begin
            burst_left--;
            gap = 0;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                burst_left = $urandom_range(20, 80);
                gap = 0;
            end else if (pick < 55) begin
                gap = 0;
            end else begin
                gap = pick_gap();
            end
        end
        if (gap > 0) begin
            pt_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pt_if.valid           <= 1'b1;
        pt_if.pos_x           <= p.x;
        pt_if.pos_y           <= p.y;
        pt_if.pos_z           <= p.z;
        pt_if.corner_lo_lo_lo <= p.corner[0];
        pt_if.corner_hi_lo_lo <= p.corner[1];
        pt_if.corner_lo_hi_lo <= p.corner[2];
        pt_if.corner_hi_hi_lo <= p.corner[3];
        pt_if.corner_lo_lo_hi <= p.corner[4];
        pt_if.corner_hi_lo_hi <= p.corner[5];
        pt_if.corner_lo_hi_hi <= p.corner[6];
        pt_if.corner_hi_hi_hi <= p.corner[7];
        do @(posedge clk); while (!pt_if.ready);
        interp_q.push_back(known ? typed : interpolate_point(p));
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge clk); while (!cfg_if.ready);
        case (idx)
            REG_X_SIZE: vol_cfg.x_size = data;
            REG_Y_SIZE: vol_cfg.y_size = data;
            REG_Z_SIZE: vol_cfg.z_size = data;
            default: ;
        endcase
    endtask

    task automatic set_volume(int x, int y, int z, bit with_unused);
        pt_if.valid <= 1'b0;
        while (interp_q.size() != 0) @(posedge clk);
        write_reg(REG_X_SIZE, SIZE_W'(x));
        write_reg(REG_Y_SIZE, SIZE_W'(y));
        write_reg(REG_Z_SIZE, SIZE_W'(z));
        if (with_unused) begin
            write_reg(REG_UNUSED, SIZE_W'($urandom));
        end
        cfg_if.valid <= 1'b0;
    endtask

    always @(posedge clk) begin
        int unsigned roll;
        if (stall_left > 0) begin
            res_if.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            res_if.ready <= 1'b1;
            if (calm_left > 0) begin
                calm_left <= calm_left - 1;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 3) begin
                    calm_left <= $urandom_range(20, 120);
                end else if (roll < 25) begin
                    stall_left <= pick_gap();
                end
            end
        end
    end

    always @(posedge clk) begin
        t_result want;
        if (rst_n && res_if.valid && res_if.ready) begin
            if (interp_q.size() == 0) begin
                mismatch_count++;
                $display("%0t: result beat with nothing expected, value %h inside %b",
                         $time, res_if.interp_value, res_if.inside_res);
            end else begin
                want = interp_q.pop_front();
                if (res_if.interp_value !== want.value) begin
                    mismatch_count++;
                    $display("%0t: interp_value expected %h actual %h",
                             $time, want.value, res_if.interp_value);
                end
                if (res_if.inside_res !== want.hit) begin
                    mismatch_count++;
                    $display("%0t: inside_res expected %b actual %b",
                             $time, want.hit, res_if.inside_res);
                end
            end
        end
    end

    initial begin
        int     px[NUM_PHASES] = '{1, 1024, 2047, 0, 256, 256, -1, -1, 5};
        int     py[NUM_PHASES] = '{1, 1024, 2047, 256, 0, 256, -1, -1, 1024};
        int     pz[NUM_PHASES] = '{1, 1024, 2047, 256, 256, 0, -1, -1, 2047};
        t_point p;

        rst_n = 1'b0;
        pt_if.valid = 1'b0;
        pt_if.pos_x = '0;
        pt_if.pos_y = '0;
        pt_if.pos_z = '0;
        pt_if.corner_lo_lo_lo = '0;
        pt_if.corner_hi_lo_lo = '0;
        pt_if.corner_lo_hi_lo = '0;
        pt_if.corner_hi_hi_lo = '0;
        pt_if.corner_lo_lo_hi = '0;
        pt_if.corner_hi_lo_hi = '0;
        pt_if.corner_lo_hi_hi = '0;
        pt_if.corner_hi_hi_hi = '0;
        res_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = REG_X_SIZE;
        cfg_if.data = '0;
        vol_cfg.x_size = SIZE_RESET;
        vol_cfg.y_size = SIZE_RESET;
        vol_cfg.z_size = SIZE_RESET;

        p = point_at(0, 0, 0, '0);
        p.corner[0] = '1;
        add_row(p, 1, '1, 1'b1);
        p = point_at(0, 0, 0, '1);
        p.corner[0] = '0;
        add_row(p, 1, '0, 1'b1);
        add_row(point_at(COORD_MAX, COORD_MAX, COORD_MAX, '1), 1, '0, 1'b0);
        add_row(point_at(COORD_MIN, COORD_MIN, COORD_MIN, '1), 1, '0, 1'b0);
        add_row(point_at(-128, 0, 0, '1), 1, '0, 1'b0);
        add_row(point_at(0, -128, 0, '1), 1, '0, 1'b0);
        add_row(point_at(0, 0, -128, '1), 1, '0, 1'b0);
        p = point_at(-127, 3, 0, '0);
        for (int i = 0; i < 8; i++) p.corner[i] = t_sample'($urandom);
        add_row(p, 0, '0, 1'b0);
        p = point_at(-1, -1, -1, '0);
        for (int i = 0; i < 8; i++) p.corner[i] = t_sample'($urandom);
        add_row(p, 0, '0, 1'b0);
        p = point_at(65407, 65407, 65407, '0);
        for (int i = 0; i < 8; i++) p.corner[i] = t_sample'($urandom);
        add_row(p, 0, '0, 1'b0);
        add_row(point_at(65408, 0, 0, '1), 1, '0, 1'b0);
        add_row(point_at(0, 65408, 0, '1), 1, '0, 1'b0);
        add_row(point_at(0, 0, 65408, '1), 1, '0, 1'b0);
        p = point_at(255 * 256, 255 * 256, 255 * 256, '0);
        p.corner[0] = 16'h1234;
        add_row(p, 1, 16'h1234, 1'b1);
        p = point_at(128, 0, 0, '0);
        p.corner[1] = '1;
        add_row(p, 0, '0, 1'b0);
        p = point_at(0, 128, 0, '0);
        p.corner[2] = '1;
        add_row(p, 0, '0, 1'b0);
        p = point_at(0, 0, 128, '0);
        p.corner[4] = '1;
        add_row(p, 0, '0, 1'b0);
        add_row(point_at(255, 255, 255, '1), 1, '1, 1'b1);
        add_row(point_at(65407, 200, 77, '1), 1, '1, 1'b1);
        add_row(point_at($urandom_range(0, 9000), $urandom_range(0, 9000),
                         $urandom_range(0, 9000), '0), 1, '0, 1'b1);
        p = point_at(300 + $urandom_range(0, 255), 1000, 4000 + $urandom_range(0, 255), '0);
        for (int i = 0; i < 8; i++) p.corner[i] = t_sample'($urandom);
        add_row(p, 0, '0, 1'b0);
        p = point_at(16'h12AA, 16'h3455, 16'h00FF, '0);
        for (int i = 0; i < 8; i++) p.corner[i] = i[0] ? 16'hAAAA : 16'h5555;
        add_row(p, 0, '0, 1'b0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i]) begin
            send_point(rows[i].pt, rows[i].known, rows[i].res);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            set_volume(px[ph] < 0 ? $urandom_range(1, 2047) : px[ph],
                       py[ph] < 0 ? $urandom_range(1, 2047) : py[ph],
                       pz[ph] < 0 ? $urandom_range(1, 2047) : pz[ph], ph == 6);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_point(rand_point(), 0, '0);
            end
        end

        pt_if.valid <= 1'b0;
        while (interp_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/tvi_pkg.sv
design/tvi_ifs.sv
design/tvi_range_check.sv
design/trilinear_voxel_interpolator.sv
dv/tb_top.sv
